// ===== src/etd_pkg.sv =====
// Shared types, constants and codes for the event timestamp deframer.
package etd_pkg;

    localparam int WORD_W   = 32;
    localparam int PART_W   = 16;
    localparam int CHAN_W   = 15;
    localparam int TIME_W   = 48;
    localparam int WCOUNT_W = 14;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam int ETD_MAX_EVENT_WORDS = 8192;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [WORD_W-1:0] TERMINATOR = '1;

    localparam logic [TIME_W-1:0] JUMP_LIMIT_RESET   = 48'd1000000000;
    localparam logic [CHAN_W-1:0] CHANNEL_BASE_RESET = 15'd1000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_LIMIT   = 1'b0,
        CFG_CHANNEL_BASE = 1'b1
    } t_cfg_idx;

    // Event status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL   = 2'd0,
        ST_SPURIOUS = 2'd1,
        ST_ORDER    = 2'd2,
        ST_JUMP     = 2'd3
    } t_status;

    // One closed event as handed from the front to the back
    typedef struct packed {
        logic [PART_W-1:0]   high_part;
        logic [PART_W-1:0]   mid_part;
        logic [PART_W-1:0]   low_part;
        logic [WCOUNT_W-1:0] word_count;
    } t_frame;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== src/etd_front.sv =====
// Front end: accepts words, tracks the open event and closes it into a frame.
module etd_front
    import etd_pkg::*;
#(
    parameter int MAX_EVENT_WORDS = ETD_MAX_EVENT_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_stall,
    input  logic [CHAN_W-1:0] i_channel_base,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_frame            o_frame
);

    localparam int NAT_W = $clog2(MAX_EVENT_WORDS + 1);
    localparam int CNT_W = (NAT_W > WCOUNT_W) ? NAT_W : WCOUNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EVENT_WORDS);

    logic              r_in_event, n_in_event;
    logic [PART_W-1:0] r_low, n_low, r_mid, n_mid, r_high, n_high;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    logic              accept, is_term;
    logic [CHAN_W:0]   chan, ch_low, ch_mid, ch_high;
    logic [PART_W-1:0] val, base_low, base_mid, base_high;
    logic [PART_W-1:0] cap_low, cap_mid, cap_high;
    logic [CNT_W-1:0]  base_cnt, cap_cnt;

    // Stall only when no room for a closing frame
    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign is_term = (i_word == TERMINATOR);

    // Channel decode, no wrap past the 15-bit range
    assign chan    = {1'b0, i_word[CHAN_W-1:0]};
    assign val     = i_word[WORD_W-1 -: PART_W];
    assign ch_low  = {1'b0, i_channel_base};
    assign ch_mid  = ch_low + (CHAN_W+1)'(1);
    assign ch_high = ch_low + (CHAN_W+1)'(2);

    // A new event starts from cleared parts
    assign base_low  = r_in_event ? r_low  : '0;
    assign base_mid  = r_in_event ? r_mid  : '0;
    assign base_high = r_in_event ? r_high : '0;
    assign base_cnt  = r_in_event ? r_cnt  : '0;

    always_comb begin
        cap_low  = base_low;
        cap_mid  = base_mid;
        cap_high = base_high;
        if (chan == ch_low) begin
            cap_low = val;
        end else if (chan == ch_mid) begin
            cap_mid = val;
        end else if (chan == ch_high) begin
            cap_high = val;
        end
        cap_cnt = (base_cnt < CNT_MAX) ? base_cnt + CNT_W'(1) : base_cnt;
    end

    // Event tracking
    always_comb begin
        n_in_event = r_in_event;
        n_low      = r_low;
        n_mid      = r_mid;
        n_high     = r_high;
        n_cnt      = r_cnt;
        o_push     = 1'b0;
        if (accept && (r_in_event || !is_term)) begin
            if (is_term) begin
                o_push     = 1'b1;
                n_in_event = 1'b0;
                n_low      = '0;
                n_mid      = '0;
                n_high     = '0;
                n_cnt      = '0;
            end else begin
                n_in_event = 1'b1;
                n_low      = cap_low;
                n_mid      = cap_mid;
                n_high     = cap_high;
                n_cnt      = cap_cnt;
            end
        end
    end

    assign o_frame.low_part   = cap_low;
    assign o_frame.mid_part   = cap_mid;
    assign o_frame.high_part  = cap_high;
    assign o_frame.word_count = cap_cnt[WCOUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_event <= 1'b0;
            r_low      <= '0;
            r_mid      <= '0;
            r_high     <= '0;
            r_cnt      <= '0;
        end else begin
            r_in_event <= n_in_event;
            r_low      <= n_low;
            r_mid      <= n_mid;
            r_high     <= n_high;
            r_cnt      <= n_cnt;
        end
    end

endmodule

// ===== src/etd_queue.sv =====
// Short frame queue between the front and the back.
module etd_queue
    import etd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_frame  i_frame,
    input  logic    i_pop,
    output t_frame  o_head,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_frame           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/etd_back.sv =====
// Back end: classifies each frame against the last good time and holds the result.
module etd_back
    import etd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [TIME_W-1:0]   i_jump_limit,
    input  t_frame              i_head,
    input  t_q_stat             i_q_stat,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [TIME_W-1:0]   o_timestamp,
    output logic [WCOUNT_W-1:0] o_word_count,
    output logic [STATUS_W-1:0] o_status
);

    logic                r_valid;
    logic [TIME_W-1:0]   r_time;
    logic [WCOUNT_W-1:0] r_wcount;
    t_status             r_status;
    logic [TIME_W-1:0]   r_last_good;
    logic                r_seen;

    logic                spurious;
    logic [TIME_W-1:0]   t_full, delta;
    t_status             status;

    assign o_pop = !i_q_stat.empty && (!r_valid || !i_stall);

    // Classification
    assign t_full   = {i_head.high_part, i_head.mid_part, i_head.low_part};
    assign spurious = (i_head.low_part == i_head.mid_part)
                   && (i_head.mid_part == i_head.high_part);
    assign delta    = t_full - r_last_good;

    always_comb begin
        if (spurious) begin
            status = ST_SPURIOUS;
        end else if (t_full < r_last_good) begin
            status = ST_ORDER;
        end else if (r_seen && (delta > i_jump_limit)) begin
            status = ST_JUMP;
        end else begin
            status = ST_NORMAL;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_time   <= spurious ? '0 : t_full;
            r_wcount <= i_head.word_count;
            r_status <= status;
        end
    end

    // Output valid and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_last_good <= '0;
            r_seen      <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_seen  <= 1'b1;
                if (status == ST_NORMAL) begin
                    r_last_good <= t_full;
                end
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_timestamp  = r_time;
    assign o_word_count = r_wcount;
    assign o_status     = r_status;

endmodule

// ===== src/event_timestamp_deframer_unit.sv =====
// Top level of the event timestamp deframer: config registers and front/queue/back.
//
//  channel | valid       | flow control | payload
//  --------+-------------+--------------+------------------------------------------
//  input   | i_valid     | o_stall      | i_word
//  output  | o_valid     | i_stall      | o_timestamp, o_word_count, o_status
//  config  | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word is taken per cycle while o_stall is low; a terminator's frame enters the
// queue at the edge that takes it, and the back registers it from the queue head
// once its result register is free.
// Sustained rate is one item per cycle while neither side stalls, set by the combinational back-end compare.
// Reset is synchronous, active low; it clears event state and the last good time.
// The input stalls only while the four-entry frame queue is full.
module event_timestamp_deframer_unit
    import etd_pkg::*;
#(
    parameter int MAX_EVENT_WORDS = ETD_MAX_EVENT_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_word,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [TIME_W-1:0]    o_timestamp,
    output logic [WCOUNT_W-1:0]  o_word_count,
    output logic [STATUS_W-1:0]  o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data
);

    logic [TIME_W-1:0] r_jump_limit;
    logic [CHAN_W-1:0] r_channel_base;

    logic    push, pop;
    t_frame  frame, head;
    t_q_stat q_stat;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit   <= JUMP_LIMIT_RESET;
            r_channel_base <= CHANNEL_BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_JUMP_LIMIT:   r_jump_limit   <= i_cfg_data;
                CFG_CHANNEL_BASE: r_channel_base <= i_cfg_data[CHAN_W-1:0];
                default:          r_jump_limit   <= r_jump_limit;
            endcase
        end
    end

    etd_front #(
        .MAX_EVENT_WORDS(MAX_EVENT_WORDS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_word         (i_word),
        .o_stall        (o_stall),
        .i_channel_base (r_channel_base),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_frame        (frame)
    );

    etd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    etd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_jump_limit (r_jump_limit),
        .i_head       (head),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_timestamp  (o_timestamp),
        .o_word_count (o_word_count),
        .o_status     (o_status)
    );

endmodule

// ===== sim/etd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the event timestamp deframer: watches every channel, predicts events, compares.
module etd_checker
    import etd_pkg::*;
#(
    parameter int MAX_EVENT_WORDS = ETD_MAX_EVENT_WORDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // word input channel
    input  logic                 i_word_valid,
    input  logic                 i_word_stall,
    input  logic [WORD_W-1:0]    i_word,
    // event output channel
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic [TIME_W-1:0]    i_timestamp,
    input  logic [WCOUNT_W-1:0]  i_word_count,
    input  logic [STATUS_W-1:0]  i_status,
    // register write channel
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TIME_W-1:0]    i_cfg_data,
    // tallies for the top
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_words,
    output int                   o_events,
    output int                   o_spurious,
    output int                   o_order,
    output int                   o_jump
);

    // One closed event as it should leave the block
    typedef struct packed {
        logic [TIME_W-1:0]   timestamp;
        logic [WCOUNT_W-1:0] word_count;
        logic [STATUS_W-1:0] status;
    } t_event_result;

    t_event_result expected_events[$];

    // Register copies
    logic [TIME_W-1:0] jump_limit;
    logic [CHAN_W-1:0] chan_base;

    // Deframer state
    logic              open_event;
    logic [PART_W-1:0] low_q;
    logic [PART_W-1:0] mid_q;
    logic [PART_W-1:0] high_q;
    int                event_words;
    logic [TIME_W-1:0] last_good;
    logic              any_event;

    // Take one accepted word; a terminator inside an event closes it
    task automatic deframe_word(input logic [WORD_W-1:0] w);
        t_event_result     r;
        t_status           st;
        logic [TIME_W-1:0] t;
        logic [15:0]       chan;
        if (open_event || w != TERMINATOR) begin
            if (!open_event) begin
                open_event  = 1'b1;
                low_q       = '0;
                mid_q       = '0;
                high_q      = '0;
                event_words = 0;
            end
            if (event_words < MAX_EVENT_WORDS)
                event_words++;
            // channel match without wrap: base+1/base+2 above 0x7FFF never match
            chan = {1'b0, w[CHAN_W-1:0]};
            if (chan == {1'b0, chan_base})
                low_q = w[31:16];
            else if (chan == {1'b0, chan_base} + 16'd1)
                mid_q = w[31:16];
            else if (chan == {1'b0, chan_base} + 16'd2)
                high_q = w[31:16];

            if (w == TERMINATOR) begin
                // spurious beats out of order, which beats jump
                if (low_q == mid_q && mid_q == high_q) begin
                    t  = '0;
                    st = ST_SPURIOUS;
                    o_spurious++;
                end else begin
                    t = {high_q, mid_q, low_q};
                    if (t < last_good) begin
                        st = ST_ORDER;
                        o_order++;
                    end else if (any_event && (t - last_good) > jump_limit) begin
                        st = ST_JUMP;
                        o_jump++;
                    end else begin
                        st        = ST_NORMAL;
                        last_good = t;
                    end
                end
                r.timestamp  = t;
                r.word_count = WCOUNT_W'(event_words);
                r.status     = st;
                expected_events.push_back(r);
                any_event   = 1'b1;
                open_event  = 1'b0;
                low_q       = '0;
                mid_q       = '0;
                high_q      = '0;
                event_words = 0;
            end
        end
    endtask

    // Compare one delivered event with the oldest prediction
    task automatic check_event();
        t_event_result want;
        o_events++;
        if (expected_events.size() == 0) begin
            o_errors++;
            $display("%0t: unexpected event, expected none, got ts %h count %0d status %0d",
                     $time, i_timestamp, i_word_count, i_status);
        end else begin
            want = expected_events.pop_front();
            if (i_timestamp !== want.timestamp) begin
                o_errors++;
                $display("%0t: timestamp mismatch, expected %h, got %h",
                         $time, want.timestamp, i_timestamp);
            end
            if (i_word_count !== want.word_count) begin
                o_errors++;
                $display("%0t: word count mismatch, expected %0d, got %0d",
                         $time, want.word_count, i_word_count);
            end
            if (i_status !== want.status) begin
                o_errors++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, i_status);
            end
        end
    endtask

    // Everything sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            jump_limit  = JUMP_LIMIT_RESET;
            chan_base   = CHANNEL_BASE_RESET;
            open_event  = 1'b0;
            low_q       = '0;
            mid_q       = '0;
            high_q      = '0;
            event_words = 0;
            last_good   = '0;
            any_event   = 1'b0;
            expected_events.delete();
            o_errors    = 0;
            o_words     = 0;
            o_events    = 0;
            o_spurious  = 0;
            o_order     = 0;
            o_jump      = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_JUMP_LIMIT)
                    jump_limit = i_cfg_data;
                else if (i_cfg_index == CFG_CHANNEL_BASE)
                    chan_base = i_cfg_data[CHAN_W-1:0];
            end
            if (i_word_valid && !i_word_stall) begin
                deframe_word(i_word);
                o_words++;
            end
            if (i_res_valid && !i_res_stall)
                check_event();
        end
        o_pending = expected_events.size();
    end

endmodule

// ===== sim/tb_event_timestamp_deframer_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the event timestamp deframer: stimulus, flow control and verdict.
module tb_event_timestamp_deframer_unit;
    import etd_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RUN_LIMIT   = 1000000;
    localparam int PHASE_WORDS = 250;
    localparam int QUIET_WORDS = 150;
    localparam int SETTLE      = 4;
    localparam int DRAIN       = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [WORD_W-1:0]    i_word      = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_JUMP_LIMIT;
    logic [TIME_W-1:0]    i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [TIME_W-1:0]    o_timestamp;
    logic [WCOUNT_W-1:0]  o_word_count;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_cfg_ready;

    int n_errors;
    int n_pending;
    int n_words;
    int n_events;
    int n_spurious;
    int n_order;
    int n_jump;

    // Stimulus state
    logic              idle_off   = 1'b0;
    int                gap_pct    = 0;
    int                words_sent = 0;
    int                settings   = 0;
    int                cycle_count = 0;
    logic [CHAN_W-1:0] cur_base   = CHANNEL_BASE_RESET;
    logic [TIME_W-1:0] cur_jump   = JUMP_LIMIT_RESET;
    logic [TIME_W-1:0] prev_time  = '0;

    event_timestamp_deframer_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_word       (i_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_timestamp  (o_timestamp),
        .o_word_count (o_word_count),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    etd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (i_valid),
        .i_word_stall (o_stall),
        .i_word       (i_word),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_timestamp  (o_timestamp),
        .i_word_count (o_word_count),
        .i_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (n_errors),
        .o_pending    (n_pending),
        .o_words      (n_words),
        .o_events     (n_events),
        .o_spurious   (n_spurious),
        .o_order      (n_order),
        .o_jump       (n_jump)
    );

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver stalls: quiet stretches then bursts of random length
    initial begin
        forever begin
            @(negedge i_clk);
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            if (!idle_off) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // Offer one word and hold it until the block takes it; called at a falling edge
    task automatic send_word(input logic [WORD_W-1:0] w);
        int gap;
        gap = 0;
        if (!idle_off && $urandom_range(1, 100) <= gap_pct)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // Word carrying one timestamp part; bit 15 is don't-care
    function automatic logic [WORD_W-1:0] part_word(input int part, input logic [PART_W-1:0] val);
        logic [CHAN_W-1:0] chan;
        chan = cur_base + CHAN_W'(part);
        return {val, 1'($urandom_range(0, 1)), chan};
    endfunction

    // Any non-terminator word, sometimes on a channel next to the timestamp ones
    function automatic logic [WORD_W-1:0] filler_word();
        logic [WORD_W-1:0] w;
        w = $urandom;
        if ($urandom_range(0, 7) == 0)
            w[CHAN_W-1:0] = ($urandom_range(0, 1) == 0) ? cur_base - CHAN_W'(1)
                                                        : cur_base + CHAN_W'(3);
        if (w == TERMINATOR)
            w[0] = 1'b0;
        return w;
    endfunction

    // Low, mid, high in order, then the terminator
    task automatic send_parts(input logic [TIME_W-1:0] t);
        send_word(part_word(0, t[15:0]));
        send_word(part_word(1, t[31:16]));
        send_word(part_word(2, t[47:32]));
        send_word(TERMINATOR);
    endtask

    // Event aiming at time t: parts in rotated order, stale values, drops, fillers
    task automatic send_timed_event(input logic [TIME_W-1:0] t, input int fillers);
        int lead;
        int start;
        int p;
        lead  = $urandom_range(0, fillers);
        start = $urandom_range(0, 2);
        repeat (lead) send_word(filler_word());
        for (int k = 0; k < 3; k++) begin
            p = (start + k) % 3;
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 7) == 0)
                    send_word(part_word(p, PART_W'($urandom)));
                send_word(part_word(p, t[16*p +: 16]));
            end
        end
        repeat (fillers - lead) send_word(filler_word());
        send_word(TERMINATOR);
    endtask

    // Step sizes from tiny to wide
    function automatic logic [TIME_W-1:0] rand_step();
        case ($urandom_range(0, 3))
            0:       return TIME_W'($urandom_range(0, 15));
            1:       return TIME_W'($urandom_range(0, 1000000));
            2:       return TIME_W'($urandom);
            default: return {PART_W'($urandom_range(0, 3)), 32'($urandom)};
        endcase
    endfunction

    // Random events until n more words have gone in
    task automatic random_phase(input int n);
        int                stop_at;
        logic [TIME_W-1:0] t;
        logic [PART_W-1:0] v;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 7) == 0)
                case ($urandom_range(0, 4))
                    0, 1:    gap_pct = 0;
                    2:       gap_pct = 10;
                    3:       gap_pct = 25;
                    default: gap_pct = 50;
                endcase
            case ($urandom_range(0, 11))
                0, 1, 2, 3: begin
                    t = prev_time + rand_step();
                    prev_time = t;
                    send_timed_event(t, $urandom_range(0, 6));
                end
                4: begin
                    t = prev_time + cur_jump;
                    prev_time = t;
                    send_timed_event(t, $urandom_range(0, 3));
                end
                5: begin
                    t = prev_time + cur_jump + TIME_W'(1) + rand_step();
                    send_timed_event(t, $urandom_range(0, 3));
                end
                6, 7: begin
                    t = prev_time - TIME_W'(1) - rand_step();
                    send_timed_event(t, $urandom_range(0, 3));
                end
                8: begin
                    v = PART_W'($urandom);
                    send_timed_event({v, v, v}, $urandom_range(0, 3));
                end
                9: begin
                    t = {PART_W'($urandom), 32'($urandom)};
                    prev_time = t;
                    send_timed_event(t, $urandom_range(0, 6));
                end
                10: begin
                    send_timed_event(rand_step(), $urandom_range(0, 3));
                end
                default: begin
                    // noise: stray terminators, short and broken events
                    repeat ($urandom_range(1, 5))
                        case ($urandom_range(0, 2))
                            0:       send_word(TERMINATOR);
                            1:       send_word($urandom);
                            default: send_word(part_word($urandom_range(0, 2),
                                                         PART_W'($urandom)));
                        endcase
                    send_word(TERMINATOR);
                end
            endcase
        end
    endtask

    // Register writes only once the block has gone quiet
    task automatic write_reg(input t_cfg_idx idx, input logic [TIME_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [TIME_W-1:0] jump, input logic [CHAN_W-1:0] base);
        i_valid <= 1'b0;
        while (n_pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        write_reg(CFG_JUMP_LIMIT, jump);
        write_reg(CFG_CHANNEL_BASE, TIME_W'(base));
        cur_jump = jump;
        cur_base = base;
        settings++;
    endtask

    // Main sequence
    initial begin
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] t1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        settings = 1;

        // Directed events at reset settings
        gap_pct = 20;
        t0 = {16'h0001, 16'h0002, 16'h0003};
        send_word(TERMINATOR);                 // terminator outside an event
        send_word(32'h0000_0000);
        send_parts(t0);                        // first event, big step, still normal
        send_word(TERMINATOR);                 // doubled terminator ignored
        send_word(32'hFFFF_FFFE);
        send_word(TERMINATOR);                 // no parts: spurious
        send_word(part_word(0, 16'h0001));
        send_word(TERMINATOR);                 // out of order
        send_parts(t0 + JUMP_LIMIT_RESET + TIME_W'(1));   // one past the limit: jump
        t1 = t0 + JUMP_LIMIT_RESET;
        send_parts(t1);                        // exactly the limit: normal
        t1 = t1 + 48'd5;
        send_word(part_word(0, 16'hAAAA));     // later value of a part wins
        send_parts(t1);
        send_word(part_word(0, 16'h1234));
        send_word(part_word(1, 16'h1234));
        send_word(part_word(2, 16'h1234));
        send_word(TERMINATOR);                 // equal nonzero parts: spurious
        send_word(32'h8000_7FFF);
        send_word(TERMINATOR);
        prev_time = t1;

        random_phase(PHASE_WORDS);

        // Zero limit, base at the bottom
        apply_settings('0, '0);
        send_word(32'h0000_0000);
        send_word(TERMINATOR);
        random_phase(PHASE_WORDS);

        // Widest limit, base at the top: terminator also writes the high part
        apply_settings('1, 15'd32765);
        send_word(part_word(0, 16'h1111));
        send_word(part_word(1, 16'h2222));
        send_word(TERMINATOR);
        send_word(32'h0000_0001);
        send_word(TERMINATOR);
        random_phase(PHASE_WORDS);

        apply_settings({PART_W'($urandom_range(0, 3)), 32'($urandom)},
                       CHAN_W'($urandom_range(0, 32765)));
        random_phase(PHASE_WORDS);

        apply_settings(JUMP_LIMIT_RESET, CHAN_W'($urandom_range(0, 32765)));
        random_phase(PHASE_WORDS - QUIET_WORDS);
        idle_off = 1'b1;
        random_phase(QUIET_WORDS);
        i_valid <= 1'b0;

        // Drain
        while (n_pending != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("Covered %0d words over %0d register settings, %0d events compared:",
                 n_words, settings, n_events);
        $display("  %0d normal, %0d spurious, %0d out of order, %0d jump",
                 n_events - n_spurious - n_order - n_jump, n_spurious, n_order, n_jump);
        if (n_errors == 0 && n_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            if (n_pending != 0)
                $display("%0t: %0d expected events never came out", $time, n_pending);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
